// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl of the dilation block
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ogdd_pkg.sv =====
// shared types, constants and the disk span table of the dilation block
// no dependencies
package ogdd_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 15;

    // field and register widths
    localparam int POS_W = 8;
    localparam int VAL_W = 8;
    localparam int OUT_W = 7;
    localparam int DIM_W = 9;
    localparam int RAD_W = 4;
    localparam int IDX_W = 2;

    // cell store addressing: row in the upper bits, column in the lower bits
    localparam int COL_AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W = ROW_AW + COL_AW;
    localparam int STORE_DEPTH = 2 ** ADDR_W;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RADIUS     = 2'd2;

    localparam logic [DIM_W-1:0] RST_MAP_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0] RST_MAP_HEIGHT = 9'd256;
    localparam logic [RAD_W-1:0] RST_RADIUS     = 4'd0;

    localparam logic REQ_LOAD = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_OUTSIDE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                kind;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
    } t_cmd;

    // effective (clamped) map geometry
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [RAD_W-1:0] radius;
    } t_cfg;

    // half-span of the disk row at offset d: floor(sqrt(r*r - d*d))
    function automatic logic [RAD_W-1:0] span_lut(input logic [RAD_W-1:0] r,
                                                  input logic [RAD_W-1:0] d);
        int v;
        logic [RAD_W-1:0] n;
        v = int'(r) * int'(r) - int'(d) * int'(d);
        n = '0;
        for (int s = 1; s < 2 ** RAD_W; s++) begin
            if (s * s <= v) begin
                n = RAD_W'(s);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/ogdd_in_if.sv =====
// request channel of the dilation block: load or query one cell
// no dependencies
interface ogdd_in_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [7:0]        row;
    logic [7:0]        col;
    logic signed [7:0] cell_value;

    modport source (output valid, req_type, row, col, cell_value, input ready);
    modport sink   (input valid, req_type, row, col, cell_value, output ready);
endinterface

// ===== rtl/core/ogdd_out_if.sv =====
// result channel of the dilation block: one word per query
// no dependencies
interface ogdd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] dilated_value;
    logic       query_outside;

    modport source (output valid, dilated_value, query_outside, input ready);
    modport sink   (input valid, dilated_value, query_outside, output ready);
endinterface

// ===== rtl/core/occupancy_grid_disk_dilation.sv =====
// occupancy grid disk dilation: max over a clipped disk of a signed cell grid
// load: no result; written to the cell store as the back takes it from the queue when idle
// query: the back sets up and scans each disk row, then drains and finishes; a query outside
// the map goes straight to finish; the back takes its next command once the result is registered;
// one store read port, one cell per cycle, sets the rate
// reset: map 256 x 256, radius 0, queue and control cleared; cell store kept
module occupancy_grid_disk_dilation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ogdd_in_if.sink                       i_req,
    ogdd_out_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [ogdd_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [ogdd_pkg::DIM_W-1:0]    i_cfg_data
);
    import ogdd_pkg::*;

    `include "assert_macros.svh"

    logic [DIM_W-1:0] r_width, r_height;
    logic [RAD_W-1:0] r_radius;
    t_cfg             cfg;
    logic             cmd_valid;
    logic             cmd_ready;
    t_cmd             cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_MAP_WIDTH;
            r_height <= RST_MAP_HEIGHT;
            r_radius <= RST_RADIUS;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MAP_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_MAP_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_RADIUS) begin
                r_radius <= i_cfg_data[RAD_W-1:0];
            end
        end
    end

    // clamp geometry to the store size
    always_comb begin
        cfg.width  = (int'(r_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : r_width;
        cfg.height = (int'(r_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : r_height;
        cfg.radius = (int'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_radius;
    end

    ogdd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (cfg),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    ogdd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_rsp       (o_rsp)
    );

    `ASSERT_IMPLIES(a_outside_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.query_outside, o_rsp.dilated_value == '0, "outside query with nonzero value")
    `ASSERT_NEXT(a_cmd_hold, i_clk, i_rst_n, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd), "queued command changed while stalled")
    `ASSERT_NEXT(a_cfg_bad_idx, i_clk, i_rst_n, i_cfg_we && i_cfg_idx != CFG_MAP_WIDTH && i_cfg_idx != CFG_MAP_HEIGHT && i_cfg_idx != CFG_RADIUS, $stable({r_width, r_height, r_radius}), "unknown register index changed config")
endmodule

// ===== rtl/core/ogdd_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module ogdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/ogdd_front.sv =====
// front of the dilation block: takes request words, classifies them
// against the map bounds and queues commands for the back; uses ogdd_pkg
module ogdd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ogdd_in_if.sink       i_req,
    input  ogdd_pkg::t_cfg i_cfg,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output ogdd_pkg::t_cmd o_cmd
);
    import ogdd_pkg::*;

    t_cmd              q_in;
    logic              in_map;
    logic              push;
    logic              pop;
    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign in_map = ({1'b0, i_req.row} < i_cfg.height) && ({1'b0, i_req.col} < i_cfg.width);

    always_comb begin
        q_in.row   = i_req.row;
        q_in.col   = i_req.col;
        q_in.value = i_req.cell_value;
        priority if (i_req.req_type == REQ_LOAD) begin
            q_in.kind = CMD_LOAD;
        end else if (in_map) begin
            q_in.kind = CMD_QUERY;
        end else begin
            q_in.kind = CMD_OUTSIDE;
        end
    end

    assign i_req.ready = (r_cnt != QCNT_W'(QDEPTH));
    // loads outside the map are dropped here
    assign push = i_req.valid && i_req.ready && !((i_req.req_type == REQ_LOAD) && !in_map);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd = r_q[r_rptr];
    assign pop = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= q_in;
        end
    end
endmodule

// ===== rtl/core/ogdd_back.sv =====
// back of the dilation block: writes loads to the cell store and scans
// the disk of each query one cell per cycle; uses ogdd_pkg and ogdd_ram
module ogdd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ogdd_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  ogdd_pkg::t_cmd i_cmd,
    ogdd_out_if.source     o_rsp
);
    import ogdd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ROW    = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_row, r_col;
    logic [RAD_W-1:0]  r_rad;
    logic [POS_W-1:0]  r_k, r_hi_r;
    logic [POS_W-1:0]  r_c, r_hi_c;
    logic [OUT_W-1:0]  r_best;
    logic              r_outside;
    logic              r_rd_vld;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_value;
    logic              r_out_flag;

    logic              pop;
    logic              out_free;
    logic [POS_W-1:0]  diff;
    logic [RAD_W-1:0]  span;
    logic [DIM_W-1:0]  row_sum, col_sum;
    logic [POS_W-1:0]  lo_r, hi_r, lo_c, hi_c;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign pop = i_cmd_valid && o_cmd_ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // row window of a new query, clipped to the map
    assign row_sum = {1'b0, i_cmd.row} + DIM_W'(i_cfg.radius);
    assign lo_r = (i_cmd.row >= POS_W'(i_cfg.radius)) ? i_cmd.row - POS_W'(i_cfg.radius) : '0;
    assign hi_r = (row_sum >= i_cfg.height) ? POS_W'(i_cfg.height - 1'b1) : POS_W'(row_sum);

    // column window of the current row
    assign diff = (r_k > r_row) ? r_k - r_row : r_row - r_k;
    assign span = span_lut(r_rad, diff[RAD_W-1:0]);
    assign col_sum = {1'b0, r_col} + DIM_W'(span);
    assign lo_c = (r_col >= POS_W'(span)) ? r_col - POS_W'(span) : '0;
    assign hi_c = (col_sum >= i_cfg.width) ? POS_W'(i_cfg.width - 1'b1) : POS_W'(col_sum);

    assign ram_we    = pop && (i_cmd.kind == CMD_LOAD);
    assign ram_waddr = {ROW_AW'(i_cmd.row), COL_AW'(i_cmd.col)};
    assign ram_raddr = {ROW_AW'(r_k), COL_AW'(r_c)};

    ogdd_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.kind)
                        CMD_QUERY:   n_state = S_ROW;
                        CMD_OUTSIDE: n_state = S_FINISH;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ROW:  n_state = S_SCAN;
            S_SCAN: begin
                if (r_c == r_hi_c) begin
                    n_state = (r_k == r_hi_r) ? S_DRAIN : S_ROW;
                end
            end
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: n_state = out_free ? S_IDLE : S_FINISH;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_row     <= i_cmd.row;
            r_col     <= i_cmd.col;
            r_rad     <= i_cfg.radius;
            r_k       <= lo_r;
            r_hi_r    <= hi_r;
            r_best    <= '0;
            r_outside <= (i_cmd.kind == CMD_OUTSIDE);
        end else begin
            if (r_state == S_ROW) begin
                r_c    <= lo_c;
                r_hi_c <= hi_c;
            end
            if (r_state == S_SCAN) begin
                if (r_c == r_hi_c) begin
                    r_k <= r_k + 1'b1;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
            // negative cells never raise the maximum
            if (r_rd_vld && !ram_rdata[VAL_W-1] && (ram_rdata[OUT_W-1:0] > r_best)) begin
                r_best <= ram_rdata[OUT_W-1:0];
            end
        end
        if (r_state == S_FINISH && out_free) begin
            r_out_value <= r_best;
            r_out_flag  <= r_outside;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.dilated_value = r_out_value;
    assign o_rsp.query_outside = r_out_flag;
endmodule

// ===== verif/tb.sv =====
// self-checking bench for occupancy_grid_disk_dilation: directed table, then random map phases
// predicts each dilation word from its own copy of the grid and geometry
// depends on ogdd_pkg, ogdd_in_if, ogdd_out_if and occupancy_grid_disk_dilation
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ogdd_pkg::*;

    localparam logic REQ_QUERY   = 1'b1;
    localparam int   ITEM_TARGET = 620;
    localparam int   QUIET_TAIL  = 80;
    localparam int   STALL_LIMIT = 10000;
    localparam int   SETTLE_CYC  = 32;

    typedef enum logic [1:0] {STEP_LOAD, STEP_QUERY, STEP_GEOM} t_step_kind;

    // one row of the directed table; geometry fields used by STEP_GEOM only
    typedef struct packed {
        t_step_kind        kind;
        logic [7:0]        row;
        logic [7:0]        col;
        logic signed [7:0] value;
        logic [8:0]        width;
        logic [8:0]        height;
        logic [3:0]        radius;
        logic              has_exp;
        logic [6:0]        exp_val;
        logic              exp_out;
    } t_drill;

    typedef struct {
        logic [7:0]       row;
        logic [7:0]       col;
        logic [OUT_W-1:0] value;
        logic             outside;
    } t_dilation_due;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0] cfg_data;
    logic accept_rsp = 1'b0;

    ogdd_in_if  req_ch();
    ogdd_out_if rsp_ch();

    assign rsp_ch.ready = accept_rsp;

    occupancy_grid_disk_dilation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the grid and the geometry registers
    logic signed [VAL_W-1:0] grid_model  [0:MAX_WIDTH*MAX_HEIGHT-1];
    bit                      grid_loaded [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [DIM_W-1:0] geo_width  = RST_MAP_WIDTH;
    logic [DIM_W-1:0] geo_height = RST_MAP_HEIGHT;
    logic [RAD_W-1:0] geo_radius = RST_RADIUS;

    t_dilation_due pending_dilations [$];
    bit idle_on = 1'b1;
    int items_done, words_checked, outside_words, geometry_writes, errors;
    int stall_left, quiet_cycles;

    t_drill drill_plan [0:25] = '{
        '{STEP_LOAD,  8'd0,   8'd0,   8'sd100, 9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd0,   8'd0,   8'sd0,   9'd0,   9'd0,   4'd0,  1'b1, 7'd100, 1'b0},
        '{STEP_LOAD,  8'd255, 8'd255, 8'sd127, 9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd255, 8'd255, 8'sd0,   9'd0,   9'd0,   4'd0,  1'b1, 7'd127, 1'b0},
        '{STEP_LOAD,  8'd255, 8'd0,   8'hFF,   9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd255, 8'd0,   8'sd0,   9'd0,   9'd0,   4'd0,  1'b1, 7'd0,   1'b0},
        '{STEP_LOAD,  8'd0,   8'd255, 8'h80,   9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd0,   8'd255, 8'sd0,   9'd0,   9'd0,   4'd0,  1'b1, 7'd0,   1'b0},
        // sizes above the bound clamp to the full grid
        '{STEP_GEOM,  8'd0,   8'd0,   8'sd0,   9'd300, 9'd511, 4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd255, 8'd255, 8'sd0,   9'd0,   9'd0,   4'd0,  1'b1, 7'd127, 1'b0},
        '{STEP_GEOM,  8'd0,   8'd0,   8'sd0,   9'd1,   9'd1,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_LOAD,  8'd0,   8'd1,   8'sd55,  9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd0,   8'd1,   8'sd0,   9'd0,   9'd0,   4'd0,  1'b1, 7'd0,   1'b1},
        '{STEP_QUERY, 8'd1,   8'd0,   8'sd0,   9'd0,   9'd0,   4'd0,  1'b1, 7'd0,   1'b1},
        '{STEP_QUERY, 8'd0,   8'd0,   8'sd0,   9'd0,   9'd0,   4'd0,  1'b1, 7'd100, 1'b0},
        // empty map: loads dropped, every query outside
        '{STEP_GEOM,  8'd0,   8'd0,   8'sd0,   9'd0,   9'd256, 4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_LOAD,  8'd0,   8'd0,   8'sd5,   9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd0,   8'd0,   8'sd0,   9'd0,   9'd0,   4'd0,  1'b1, 7'd0,   1'b1},
        '{STEP_GEOM,  8'd0,   8'd0,   8'sd0,   9'd2,   9'd2,   4'd1,  1'b0, 7'd0,   1'b0},
        '{STEP_LOAD,  8'd0,   8'd1,   8'sd85,  9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_LOAD,  8'd1,   8'd0,   8'sd42,  9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_LOAD,  8'd1,   8'd1,   8'hFF,   9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd1,   8'd1,   8'sd0,   9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd0,   8'd0,   8'sd0,   9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0},
        '{STEP_GEOM,  8'd0,   8'd0,   8'sd0,   9'd2,   9'd2,   4'd15, 1'b0, 7'd0,   1'b0},
        '{STEP_QUERY, 8'd1,   8'd1,   8'sd0,   9'd0,   9'd0,   4'd0,  1'b0, 7'd0,   1'b0}
    };

    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int limit);
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    function automatic int half_span(input int r, input int d);
        int s;
        s = 0;
        while ((s + 1) * (s + 1) <= r * r - d * d) s++;
        return s;
    endfunction

    // max over the clipped disk, floored at 0; -1 if the disk touches an unloaded cell
    function automatic int disk_max(input int row, input int col);
        int w, h, r, best, span, lo_c, hi_c, idx;
        w = eff_dim(geo_width, MAX_WIDTH);
        h = eff_dim(geo_height, MAX_HEIGHT);
        r = (int'(geo_radius) > MAX_RADIUS) ? MAX_RADIUS : int'(geo_radius);
        best = 0;
        for (int k = row - r; k <= row + r; k++) begin
            if (k < 0 || k >= h) continue;
            span = half_span(r, k - row);
            lo_c = (col - span < 0) ? 0 : col - span;
            hi_c = (col + span >= w) ? w - 1 : col + span;
            for (int l = lo_c; l <= hi_c; l++) begin
                idx = k * MAX_WIDTH + l;
                if (!grid_loaded[idx]) return -1;
                if (grid_model[idx] > best) best = grid_model[idx];
            end
        end
        return best;
    endfunction

    // a query spot whose disk is fully loaded, near the origin first
    function automatic bit pick_query(output logic [7:0] row, output logic [7:0] col);
        int w, h;
        w = eff_dim(geo_width, MAX_WIDTH);
        h = eff_dim(geo_height, MAX_HEIGHT);
        for (int t = 0; t < 12; t++) begin
            if (w == 0 || h == 0) begin
                row = 8'($urandom);
                col = 8'($urandom);
                return 1'b1;
            end
            if (t < 6) begin
                row = 8'($urandom_range(0, ((h < 16) ? h : 16) - 1));
                col = 8'($urandom_range(0, ((w < 16) ? w : 16) - 1));
            end else begin
                row = 8'($urandom_range(0, h - 1));
                col = 8'($urandom_range(0, w - 1));
            end
            if (disk_max(row, col) >= 0) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [VAL_W-1:0] random_occupancy();
        case ($urandom_range(0, 9))
            0: return 8'hFF;
            1: return VAL_W'($urandom);
            default: return VAL_W'($urandom_range(0, 100));
        endcase
    endfunction

    // hands one word to the block and updates the shadow at the accepting edge
    task automatic issue(input logic kind, input logic [7:0] row, input logic [7:0] col,
                         input logic signed [7:0] value, input logic has_exp,
                         input logic [6:0] exp_val, input logic exp_out);
        int n, w, h, best, idx;
        bit in_map;
        t_dilation_due due;
        if (items_done >= ITEM_TARGET - QUIET_TAIL) idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.row        <= row;
        req_ch.col        <= col;
        req_ch.cell_value <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        w = eff_dim(geo_width, MAX_WIDTH);
        h = eff_dim(geo_height, MAX_HEIGHT);
        in_map = int'(row) < h && int'(col) < w;
        idx = int'(row) * MAX_WIDTH + int'(col);
        if (kind == REQ_LOAD) begin
            if (in_map) begin
                grid_model[idx] = value;
                grid_loaded[idx] = 1'b1;
                items_done++;
            end
        end else begin
            due.row = row;
            due.col = col;
            if (has_exp) begin
                due.value = exp_val;
                due.outside = exp_out;
            end else if (!in_map) begin
                due.value = '0;
                due.outside = 1'b1;
            end else begin
                best = disk_max(row, col);
                due.value = best[OUT_W-1:0];
                due.outside = 1'b0;
            end
            pending_dilations.push_back(due);
            items_done++;
        end
    endtask

    // drop valid, wait for every dilation word, then let queued loads land
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_dilations.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int w, input int h, input int r);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAP_WIDTH;
        cfg_data <= DIM_W'(w);
        @(posedge i_clk);
        cfg_idx  <= CFG_MAP_HEIGHT;
        cfg_data <= DIM_W'(h);
        @(posedge i_clk);
        cfg_idx  <= CFG_RADIUS;
        cfg_data <= DIM_W'(r);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        geo_width  = DIM_W'(w);
        geo_height = DIM_W'(h);
        geo_radius = RAD_W'(r);
        geometry_writes++;
    endtask

    // result side: check against the oldest prediction, stall in bursts
    always @(posedge i_clk) begin
        t_dilation_due due;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_dilations.size() == 0) begin
                $display("%0t ns: unexpected word, dilated_value %0d query_outside %0d",
                         $time, rsp_ch.dilated_value, rsp_ch.query_outside);
                errors++;
            end else begin
                due = pending_dilations.pop_front();
                if (rsp_ch.dilated_value !== due.value) begin
                    $display("%0t ns: dilated_value at (%0d,%0d) expected %0d got %0d",
                             $time, due.row, due.col, due.value, rsp_ch.dilated_value);
                    errors++;
                end
                if (rsp_ch.query_outside !== due.outside) begin
                    $display("%0t ns: query_outside at (%0d,%0d) expected %0d got %0d",
                             $time, due.row, due.col, due.outside, rsp_ch.query_outside);
                    errors++;
                end
                words_checked++;
                if (due.outside) outside_words++;
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            accept_rsp <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            accept_rsp <= 1'b0;
        end else begin
            accept_rsp <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int style, w, h, r, ew, eh, n_ops, sel;
        logic [7:0] row, col;
        logic kind;
        bit full_load;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_LOAD;
        req_ch.row        <= '0;
        req_ch.col        <= '0;
        req_ch.cell_value <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_MAP_WIDTH;
        cfg_data <= '0;
        i_rst_n  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (drill_plan[i]) begin
            if (drill_plan[i].kind == STEP_GEOM) begin
                set_geometry(drill_plan[i].width, drill_plan[i].height, drill_plan[i].radius);
            end else begin
                issue((drill_plan[i].kind == STEP_LOAD) ? REQ_LOAD : REQ_QUERY,
                      drill_plan[i].row, drill_plan[i].col, drill_plan[i].value,
                      drill_plan[i].has_exp, drill_plan[i].exp_val, drill_plan[i].exp_out);
            end
        end

        while (items_done < ITEM_TARGET) begin
            style = $urandom_range(0, 9);
            sel = $urandom_range(0, 3);
            r = (sel == 0) ? 0 : (sel == 1) ? MAX_RADIUS : $urandom_range(0, MAX_RADIUS);
            full_load = 1'b0;
            if (style <= 5) begin
                // small map loaded whole before it is queried
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
                full_load = 1'b1;
            end else if (style <= 7) begin
                w = $urandom_range(0, 1) ? MAX_WIDTH : $urandom_range(200, 511);
                h = $urandom_range(0, 1) ? MAX_HEIGHT : $urandom_range(200, 511);
                r = $urandom_range(0, 3);
            end else if (style == 8) begin
                w = $urandom_range(0, 511);
                h = $urandom_range(0, 511);
                if ($urandom_range(0, 1)) w = 0;
                else h = 0;
            end else begin
                w = $urandom_range(1, 511);
                h = $urandom_range(1, 3);
            end
            set_geometry(w, h, r);
            idle_on = ($urandom_range(0, 3) != 0) && (items_done < ITEM_TARGET - QUIET_TAIL);
            ew = eff_dim(geo_width, MAX_WIDTH);
            eh = eff_dim(geo_height, MAX_HEIGHT);
            if (full_load) begin
                for (int y = 0; y < eh; y++) begin
                    for (int x = 0; x < ew; x++) begin
                        issue(REQ_LOAD, 8'(y), 8'(x), random_occupancy(), 1'b0, '0, 1'b0);
                    end
                end
            end
            n_ops = $urandom_range(15, 40);
            repeat (n_ops) begin
                if (items_done >= ITEM_TARGET) break;
                sel = $urandom_range(0, 19);
                if (sel <= 10) begin
                    // a spot that cannot be queried safely gets loaded instead
                    kind = pick_query(row, col) ? REQ_QUERY : REQ_LOAD;
                end else if (sel <= 16) begin
                    row = 8'($urandom_range(0, (eh == 0) ? 255 : eh - 1));
                    col = 8'($urandom_range(0, (ew == 0) ? 255 : ew - 1));
                    kind = REQ_LOAD;
                end else begin
                    row = 8'($urandom_range(0, 255));
                    col = 8'($urandom_range(0, 255));
                    kind = $urandom_range(0, 1) ? REQ_QUERY : REQ_LOAD;
                    if (kind == REQ_QUERY && int'(row) < eh && int'(col) < ew
                            && disk_max(row, col) < 0) begin
                        kind = REQ_LOAD;
                    end
                end
                issue(kind, row, col, random_occupancy(), 1'b0, '0, 1'b0);
                if ($urandom_range(0, 29) == 0 && pending_dilations.size() != 0) begin
                    req_ch.valid <= 1'b0;
                    while (pending_dilations.size() != 0) @(posedge i_clk);
                end
            end
        end

        settle();
        $display("covered %0d requests over %0d map geometries, %0d words checked (%0d outside)",
                 items_done, geometry_writes, words_checked, outside_words);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ogdd_pkg.sv
rtl/core/ogdd_in_if.sv
rtl/core/ogdd_out_if.sv
rtl/core/ogdd_ram.sv
rtl/core/ogdd_front.sv
rtl/core/ogdd_back.sv
rtl/core/occupancy_grid_disk_dilation.sv
verif/tb.sv
